@@ rtl/cvd_pkg.sv @@
// Shared types, constants and the trigonometric table of the composite video demodulator.
package cvd_pkg;

  localparam int MAX_HALF_WINDOW      = 16;
  localparam int MAX_LINE_SAMPLES     = 4096;
  localparam int PHASE_TABLE_SIZE     = 1024;
  localparam int PHASE_BITS           = $clog2(PHASE_TABLE_SIZE);
  localparam int SAMPLE_FRACTION_BITS = 12;
  localparam int FULL_SHIFT           = SAMPLE_FRACTION_BITS + 13;
  localparam int PREFIX_DEPTH         = 64;
  localparam int PREFIX_AW            = $clog2(PREFIX_DEPTH);
  localparam int RESULT_CAP           = 16;
  localparam int QUEUE_DEPTH          = 2;
  localparam int NUM_LANES            = 3;

  localparam int SPL_W   = 13;
  localparam int POS_W   = 12;
  localparam int CTR_W   = 25;
  localparam int CNT_W   = 5;
  localparam int N_W     = 6;
  localparam int COL_W   = 12;
  localparam int LUMA_W  = 24;
  localparam int CHR_W   = 32;
  localparam int RING_W  = LUMA_W + 2 * CHR_W;
  localparam int HALF_W  = 5;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518853;

  // Configuration register indexes
  localparam logic [1:0] REG_PHASE_STEP       = 2'd0;
  localparam logic [1:0] REG_SAMPLES_PER_LINE = 2'd1;
  localparam logic [1:0] REG_OUT_WIDTH        = 2'd2;
  localparam logic [1:0] REG_HALF_WINDOW      = 2'd3;

  localparam logic [31:0]       RST_PHASE_STEP = 32'd1073741824;
  localparam logic [SPL_W-1:0]  RST_SPL        = 13'd910;
  localparam logic [SPL_W-1:0]  RST_OW         = 13'd640;
  localparam logic [HALF_W-1:0] RST_HALF       = 5'd2;

  typedef logic signed [15:0] coef_arr_t [NUM_LANES];
  // Lanes: red, green, blue. Q2.13 chroma weights.
  localparam coef_arr_t CI_COEF = '{16'sd7832, -16'sd2228, -16'sd9060};
  localparam coef_arr_t CQ_COEF = '{16'sd5087, -16'sd5300, 16'sd13951};

  typedef struct packed {
    logic [31:0]       phase_step;
    logic [SPL_W-1:0]  spl;
    logic [SPL_W-1:0]  ow;
    logic [HALF_W-1:0] half;
    logic [SPL_W-1:0]  step_q;
    logic [SPL_W-1:0]  step_r;
  } cvd_cfg_t;

  typedef struct packed {
    logic signed [LUMA_W-1:0] y_sum;
    logic signed [CHR_W-1:0]  i_sum;
    logic signed [CHR_W-1:0]  q_sum;
    logic [N_W-1:0]           n;
    logic [COL_W-1:0]         col;
    logic                     last;
  } pix_job_t;

  typedef enum logic [2:0] {
    F_IDLE, F_TRIG, F_MUL, F_WRITE, F_PIX, F_READ, F_PUSH, F_END
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_SUM, B_PREP, B_DIV, B_OUT
  } back_state_t;

  // Sine of 2*pi*f/2^32 by an eight-term series, rounded to Q1.14.
  function automatic logic signed [15:0] trig14(input logic [31:0] f);
    logic [63:0] g;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] mag;
    longint      sum;
    g = {33'd0, f[30:0]};
    if (g > 64'h4000_0000) g = 64'h8000_0000 - g;
    x = (g * TWO_PI_Q30) >> 32;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (f[31]) sum = -sum;
    mag = (sum < 0) ? 64'(-sum) : 64'(sum);
    mag = (mag + 64'd32768) >> 16;
    if (mag > 64'd16384) mag = 64'd16384;
    return (sum < 0) ? -$signed(16'(mag)) : $signed(16'(mag));
  endfunction

  typedef logic signed [15:0] trig_tab_t [PHASE_TABLE_SIZE];

  function automatic trig_tab_t build_sin_tab();
    trig_tab_t t;
    for (int i = 0; i < PHASE_TABLE_SIZE; i++) begin
      t[i] = trig14(32'(i) << (32 - PHASE_BITS));
    end
    return t;
  endfunction

  localparam trig_tab_t SIN_TAB = build_sin_tab();

endpackage

@@ rtl/cvd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/cvd_front.sv @@
// Front end: sample intake, subcarrier mixing, prefix ring update and pixel window jobs.
module cvd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  cvd_pkg::cvd_cfg_t cfg,
  input  logic              cfg_ready,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,
  input  logic              in_tuser,
  output logic              job_push,
  output cvd_pkg::pix_job_t job,
  input  logic              job_full
);
  import cvd_pkg::*;

  front_state_t state_r, state_nxt;

  logic [31:0]              phase_r;
  logic [POS_W-1:0]         pos_r;
  logic [SPL_W-1:0]         pix_r;
  logic [CTR_W-1:0]         center_r;
  logic [CTR_W-1:0]         crem_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [POS_W-1:0]         p_r;
  logic signed [15:0]       y_r;
  logic [PHASE_BITS-1:0]    idx_r;
  logic signed [15:0]       tc_r, ts_r;
  logic signed [31:0]       prod_c_r, prod_s_r;
  logic [LUMA_W-1:0]        lacc_r;
  logic [CHR_W-1:0]         iacc_r, qacc_r;
  logic                     lo_zero_r, empty_r;
  logic [N_W-1:0]           n_r;
  logic [COL_W-1:0]         col_r;
  pix_job_t                 job_r;

  logic                     accept, line_restart, ok_now;
  logic [CTR_W:0]           hi_w;
  logic [CTR_W-1:0]         lo_w;
  logic [CTR_W-1:0]         crem_sum, crem_adv, center_adv;
  logic                     crem_wrap;
  logic signed [31:0]       rnd_c, rnd_s;
  logic [LUMA_W-1:0]        lacc_nxt;
  logic [CHR_W-1:0]         iacc_nxt, qacc_nxt;
  logic                     ram_we;
  logic [PREFIX_AW-1:0]     ram_waddr, raddr_a, raddr_b;
  logic [RING_W-1:0]        ram_wdata, rd_a, rd_b;
  logic [LUMA_W-1:0]        la;
  logic [CHR_W-1:0]         ia, qa;

  // Last sample of the clipped window around centre c.
  function automatic logic [CTR_W:0] win_hi(input logic [CTR_W-1:0] c, input cvd_cfg_t k);
    logic [CTR_W:0] raw;
    logic [CTR_W:0] lim;
    raw = {1'b0, c} + (CTR_W+1)'(k.half) - (CTR_W+1)'(1);
    lim = (CTR_W+1)'(k.spl - SPL_W'(1));
    return (raw > lim) ? lim : raw;
  endfunction

  function automatic logic win_ok(input logic [CTR_W-1:0] c, input logic [SPL_W-1:0] pix,
                                  input logic [CNT_W-1:0] cnt, input logic [POS_W-1:0] p,
                                  input cvd_cfg_t k);
    return (cnt < CNT_W'(RESULT_CAP)) && (pix < k.ow) && (win_hi(c, k) <= (CTR_W+1)'(p));
  endfunction

  assign accept       = in_tvalid && in_tready;
  assign line_restart = in_tuser || ({1'b0, pos_r} >= cfg.spl);

  always_comb begin
    hi_w       = win_hi(center_r, cfg);
    lo_w       = (center_r > CTR_W'(cfg.half)) ? center_r - CTR_W'(cfg.half) : '0;
    ok_now     = win_ok(center_r, pix_r, cnt_r, p_r, cfg);
    crem_sum   = crem_r + CTR_W'(cfg.step_r);
    crem_wrap  = crem_sum >= CTR_W'(cfg.ow);
    crem_adv   = crem_wrap ? crem_sum - CTR_W'(cfg.ow) : crem_sum;
    center_adv = center_r + CTR_W'(cfg.step_q) + CTR_W'(crem_wrap);
    rnd_c      = (prod_c_r + 32'sd8192) >>> 14;
    rnd_s      = (prod_s_r + 32'sd8192) >>> 14;
    lacc_nxt   = ((p_r == '0) ? '0 : lacc_r) + {{(LUMA_W-16){y_r[15]}}, y_r};
    iacc_nxt   = ((p_r == '0) ? '0 : iacc_r) + CHR_W'(rnd_c);
    qacc_nxt   = ((p_r == '0) ? '0 : qacc_r) + CHR_W'(rnd_s);
    la         = lo_zero_r ? '0 : rd_a[RING_W-1 -: LUMA_W];
    ia         = lo_zero_r ? '0 : rd_a[2*CHR_W-1 -: CHR_W];
    qa         = lo_zero_r ? '0 : rd_a[CHR_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (accept) state_nxt = F_TRIG;
      F_TRIG:  state_nxt = F_MUL;
      F_MUL:   state_nxt = F_WRITE;
      F_WRITE: state_nxt = F_PIX;
      F_PIX:   state_nxt = ok_now ? F_READ : F_END;
      F_READ:  state_nxt = F_PUSH;
      F_PUSH:  if (!job_full) state_nxt = job_r.last ? F_END : F_PIX;
      F_END:   state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == F_IDLE) && cfg_ready;
    job_push  = (state_r == F_PUSH) && !job_full;
    job       = job_r;
    ram_we    = (state_r == F_WRITE);
    ram_waddr = p_r[PREFIX_AW-1:0] + PREFIX_AW'(1);
    ram_wdata = {lacc_nxt, iacc_nxt, qacc_nxt};
    raddr_a   = lo_w[PREFIX_AW-1:0];
    raddr_b   = hi_w[PREFIX_AW-1:0] + PREFIX_AW'(1);
  end

  cvd_ram #(.WIDTH(RING_W), .DEPTH(PREFIX_DEPTH)) u_ring_lo (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(raddr_a), .rdata(rd_a)
  );

  cvd_ram #(.WIDTH(RING_W), .DEPTH(PREFIX_DEPTH)) u_ring_hi (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(raddr_b), .rdata(rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      phase_r  <= '0;
      pos_r    <= '0;
      pix_r    <= '0;
      center_r <= '0;
      crem_r   <= '0;
      cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            y_r   <= $signed(in_tdata);
            idx_r <= in_tuser ? '0 : phase_r[31 -: PHASE_BITS];
            if (in_tuser) phase_r <= '0;
            if (line_restart) begin
              p_r      <= '0;
              pix_r    <= '0;
              center_r <= '0;
              crem_r   <= '0;
            end else begin
              p_r <= pos_r;
            end
          end
        end
        F_TRIG: begin
          tc_r <= SIN_TAB[idx_r + PHASE_BITS'(PHASE_TABLE_SIZE / 4)];
          ts_r <= SIN_TAB[idx_r];
        end
        F_MUL: begin
          prod_c_r <= y_r * tc_r;
          prod_s_r <= y_r * ts_r;
        end
        F_WRITE: begin
          lacc_r <= lacc_nxt;
          iacc_r <= iacc_nxt;
          qacc_r <= qacc_nxt;
          cnt_r  <= '0;
        end
        F_PIX: begin
          if (ok_now) begin
            lo_zero_r <= (lo_w == '0);
            empty_r   <= ({1'b0, lo_w} > hi_w);
            n_r       <= N_W'(hi_w - {1'b0, lo_w} + (CTR_W+1)'(1));
            col_r     <= pix_r[COL_W-1:0];
            pix_r     <= pix_r + SPL_W'(1);
            center_r  <= center_adv;
            crem_r    <= crem_adv;
            cnt_r     <= cnt_r + CNT_W'(1);
          end
        end
        F_READ: begin
          // An empty window reads as black over a single sample.
          job_r.y_sum <= empty_r ? '0 : $signed(rd_b[RING_W-1 -: LUMA_W] - la);
          job_r.i_sum <= empty_r ? '0 : $signed(rd_b[2*CHR_W-1 -: CHR_W] - ia);
          job_r.q_sum <= empty_r ? '0 : $signed(rd_b[CHR_W-1:0] - qa);
          job_r.n     <= empty_r ? N_W'(1) : n_r;
          job_r.col   <= col_r;
          job_r.last  <= !win_ok(center_r, pix_r, cnt_r, p_r, cfg);
        end
        F_END: begin
          phase_r <= phase_r + cfg.phase_step;
          if ({1'b0, p_r} >= cfg.spl - SPL_W'(1)) begin
            pos_r    <= '0;
            pix_r    <= '0;
            center_r <= '0;
            crem_r   <= '0;
          end else begin
            pos_r <= p_r + POS_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/cvd_queue.sv @@
// Short job queue between the front end and the colour back end.
module cvd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cvd_pkg::pix_job_t din,
  output logic              full,
  input  logic              pop,
  output cvd_pkg::pix_job_t dout,
  output logic              empty
);
  import cvd_pkg::*;

  localparam int QP_W = $clog2(QUEUE_DEPTH);

  pix_job_t               slot_r [QUEUE_DEPTH];
  logic [QP_W-1:0]        wp_r, rp_r;
  logic [QP_W:0]          fill_r;

  assign full  = (fill_r == (QP_W+1)'(QUEUE_DEPTH));
  assign empty = (fill_r == '0);
  assign dout  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QP_W'(1);
      if (pop) rp_r <= rp_r + QP_W'(1);
      fill_r <= fill_r + (QP_W+1)'(push) - (QP_W+1)'(pop);
    end
  end

endmodule

@@ rtl/cvd_back.sv @@
// Back end: YIQ to RGB conversion, window mean by an eight-step divider, output register.
module cvd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_pop,
  input  cvd_pkg::pix_job_t job,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,
  output logic              out_tlast
);
  import cvd_pkg::*;

  localparam int V_W   = 51;
  localparam int NUM_W = 40;

  back_state_t state_r, state_nxt;
  pix_job_t    job_r;
  logic [2:0]  step_r;
  logic [NUM_W-1:0] dsh_r;
  logic        out_valid_r;
  logic [7:0]  col_byte [NUM_LANES];
  logic        load;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (job_valid) state_nxt = B_MUL;
      B_MUL:   state_nxt = B_SUM;
      B_SUM:   state_nxt = B_PREP;
      B_PREP:  state_nxt = B_DIV;
      B_DIV:   if (step_r == 3'd7) state_nxt = B_OUT;
      B_OUT:   if (load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop    = (state_r == B_IDLE) && job_valid;
    load       = (state_r == B_OUT) && (!out_valid_r || out_tready);
    out_tvalid = out_valid_r;
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    logic signed [47:0]  pi_r, pq_r;
    logic signed [V_W-1:0] v_r;
    logic                neg_r, over_r;
    logic [NUM_W-1:0]    num_r;
    logic [7:0]          q_r;
    logic [NUM_W-1:0]    v40;
    logic                ge;

    assign v40 = v_r[NUM_W-1:0];
    assign ge  = num_r >= dsh_r;
    assign col_byte[k] = neg_r ? 8'd0 : (over_r ? 8'd255 : q_r);

    always_ff @(posedge clk) begin
      case (state_r)
        B_MUL: begin
          pi_r <= CI_COEF[k] * job_r.i_sum;
          pq_r <= CQ_COEF[k] * job_r.q_sum;
        end
        B_SUM: begin
          v_r <= (V_W'(job_r.y_sum) <<< 13) + ((V_W'(pi_r) + V_W'(pq_r)) <<< 1);
        end
        B_PREP: begin
          neg_r  <= v_r < 0;
          over_r <= v_r > $signed(V_W'(job_r.n) <<< FULL_SHIFT);
          num_r  <= (v40 << 8) - v40 + (NUM_W'(job_r.n) << (FULL_SHIFT - 1));
        end
        B_DIV: begin
          if (ge) num_r <= num_r - dsh_r;
          q_r <= {q_r[6:0], ge};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) job_r <= job;
    if (state_r == B_PREP) dsh_r <= NUM_W'(job_r.n) << (FULL_SHIFT + 7);
    else if (state_r == B_DIV) dsh_r <= dsh_r >> 1;
    if (load) begin
      out_tdata <= {4'd0, job_r.col, col_byte[2], col_byte[1], col_byte[0]};
      out_tlast <= job_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_DIV) step_r <= step_r + 3'd1;
      else step_r <= '0;
      if (load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

endmodule

@@ rtl/composite_video_yiq_demodulator.sv @@
// Top level of the composite video YIQ demodulator: configuration, pixel step divider, wiring.
//
//  channel | direction | beat contents
//  --------+-----------+------------------------------------------------------------
//  in_     | slave     | tdata: sample[15:0]; tuser: frame_start
//  out_    | master    | tdata: red, green, blue, column, zero pad; tlast: last pixel
//  cfg_    | write     | cfg_addr selects phase_step, samples_per_line, out_width, half_window
//
// The front end takes each sample through its states and adds a window read and a job push per pixel
// the sample completes; the back end finishes each pixel with its eight-step mean divider, and works
// while the front end moves on, with a two-entry job queue and the output register in between.
// After reset and after every configuration write the pixel step divider runs, and in_tready
// is low while it does. Reset is synchronous; the prefix rings need no clearing.
// A stalled output holds the back end, then fills the queue, then holds the front end.
module composite_video_yiq_demodulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample[15:0]
  input  logic        in_tuser,   // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // red[7:0], green[15:8], blue[23:16], column[35:24], pad
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);
  import cvd_pkg::*;

  logic [31:0]       step_reg_r;
  logic [SPL_W-1:0]  spl_reg_r, ow_reg_r;
  logic [HALF_W-1:0] half_reg_r;
  logic [SPL_W-1:0]  spl_c, ow_c;
  logic [HALF_W-1:0] half_c;
  cvd_cfg_t          cfg_c;

  logic              div_pend_r, div_busy_r;
  logic [3:0]        div_cnt_r;
  logic [SPL_W-1:0]  dq_r, drem_r;
  logic [SPL_W:0]    div_t;
  logic              div_ge;

  logic              job_push, job_full, job_pop, job_empty;
  pix_job_t          job_in, job_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_reg_r <= RST_PHASE_STEP;
      spl_reg_r  <= RST_SPL;
      ow_reg_r   <= RST_OW;
      half_reg_r <= RST_HALF;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PHASE_STEP:       step_reg_r <= cfg_wdata;
        REG_SAMPLES_PER_LINE: spl_reg_r  <= cfg_wdata[SPL_W-1:0];
        REG_OUT_WIDTH:        ow_reg_r   <= cfg_wdata[SPL_W-1:0];
        REG_HALF_WINDOW:      half_reg_r <= cfg_wdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    spl_c = (spl_reg_r == '0) ? SPL_W'(1) :
            ((spl_reg_r > SPL_W'(MAX_LINE_SAMPLES)) ? SPL_W'(MAX_LINE_SAMPLES) : spl_reg_r);
    ow_c  = (ow_reg_r == '0) ? SPL_W'(1) : ow_reg_r;
    if (ow_c > spl_c) ow_c = spl_c;
    half_c = (half_reg_r < HALF_W'(2)) ? HALF_W'(2) :
             ((half_reg_r > HALF_W'(MAX_HALF_WINDOW)) ? HALF_W'(MAX_HALF_WINDOW) : half_reg_r);
    cfg_c.phase_step = step_reg_r;
    cfg_c.spl        = spl_c;
    cfg_c.ow         = ow_c;
    cfg_c.half       = half_c;
    cfg_c.step_q     = dq_r;
    cfg_c.step_r     = drem_r;
  end

  // Restoring divider giving the per-pixel centre step, one quotient bit a cycle.
  assign div_t  = {drem_r, dq_r[SPL_W-1]};
  assign div_ge = div_t >= {1'b0, ow_c};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_pend_r <= 1'b1;
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (cfg_we) begin
      div_pend_r <= 1'b1;
      div_busy_r <= 1'b0;
    end else if (div_pend_r) begin
      div_pend_r <= 1'b0;
      div_busy_r <= 1'b1;
      div_cnt_r  <= '0;
      dq_r       <= spl_c;
      drem_r     <= '0;
    end else if (div_busy_r) begin
      drem_r    <= div_ge ? SPL_W'(div_t - {1'b0, ow_c}) : div_t[SPL_W-1:0];
      dq_r      <= {dq_r[SPL_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r + 4'd1;
      if (div_cnt_r == 4'(SPL_W - 1)) div_busy_r <= 1'b0;
    end
  end

  cvd_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_c), .cfg_ready(!div_pend_r && !div_busy_r),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .job_push(job_push), .job(job_in), .job_full(job_full)
  );

  cvd_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(job_push), .din(job_in), .full(job_full),
    .pop(job_pop), .dout(job_out), .empty(job_empty)
  );

  cvd_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(!job_empty), .job_pop(job_pop), .job(job_out),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  a_no_intake_during_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!div_pend_r && !div_busy_r))
    else $error("sample taken while the centre step is being computed");

  a_clamp_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_c.ow != '0) && (cfg_c.ow <= cfg_c.spl) && (cfg_c.half >= HALF_W'(2)))
    else $error("clamped configuration out of order");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("job pushed into a full queue");

  a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(div_busy_r) && !div_pend_r) |->
      (27'(dq_r) * 27'(cfg_c.ow) + 27'(drem_r) == 27'(cfg_c.spl)))
    else $error("centre step quotient and remainder inconsistent");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the composite video YIQ demodulator.

class pixel_scoreboard;
  typedef struct {
    bit [7:0]  red;
    bit [7:0]  green;
    bit [7:0]  blue;
    bit [11:0] column;
    bit        last;
  } pixel_t;

  localparam int RING_SIZE = 64;
  localparam int FLUSH_CAP = 16;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518853;
  localparam longint CI_R = 7832, CQ_R = 5087;
  localparam longint CI_G = -2228, CQ_G = -5300;
  localparam longint CI_B = -9060, CQ_B = 13951;

  bit [31:0] phase_step = 32'd1073741824;
  int        line_len = 910;
  int        pix_width = 640;
  int        half_win = 2;

  bit [31:0] phase;
  int        position, pix_index, centre, centre_rem;
  bit [23:0] luma_ring [RING_SIZE];
  bit [31:0] inph_ring [RING_SIZE];
  bit [31:0] quad_ring [RING_SIZE];

  pixel_t pending_pixels [$];
  int     errors;

  function void set_reg(int idx, bit [31:0] val);
    case (idx)
      0: phase_step = val;
      1: line_len = val[12:0];
      2: pix_width = val[12:0];
      3: half_win = val[4:0];
      default: ;
    endcase
  endfunction

  function void restart_line();
    position = 0;
    pix_index = 0;
    centre = 0;
    centre_rem = 0;
  endfunction

  // Sine of a 32-bit phase fraction in Q30, by a truncated Taylor series.
  function longint sine_q30(bit [31:0] f);
    logic [63:0] g, x, term;
    longint sum;
    g = {33'd0, f[30:0]};
    if (g > 64'h4000_0000) g = 64'h8000_0000 - g;
    x = (g * TWO_PI_Q30) >> 32;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return f[31] ? -sum : sum;
  endfunction

  function longint trig_q14(bit [31:0] f);
    longint s, mag;
    s = sine_q30(f);
    mag = ((s < 0 ? -s : s) + 32768) >> 16;
    if (mag > 16384) mag = 16384;
    return s < 0 ? -mag : mag;
  endfunction

  function bit [7:0] colour_byte(longint v, longint n);
    longint full;
    full = n << 25;
    if (v < 0) return 8'd0;
    if (v > full) return 8'd255;
    return 8'((v * 255 + full / 2) / full);
  endfunction

  function void note_sample(bit [15:0] raw, bit frame_start);
    longint y, ival, qval, ys, is, qs, n;
    int spl, ow, h, p, a, b, count, lo, hi;
    bit [31:0] ef;
    bit [23:0] dl;
    bit [31:0] di, dq;
    pixel_t px;
    y = longint'($signed(raw));
    spl = line_len < 1 ? 1 : (line_len > 4096 ? 4096 : line_len);
    ow = pix_width < 1 ? 1 : (pix_width > spl ? spl : pix_width);
    h = half_win < 2 ? 2 : (half_win > 16 ? 16 : half_win);
    count = 0;
    if (frame_start) begin
      phase = 0;
      restart_line();
    end
    if (position >= spl) restart_line();
    p = position;
    ef = {phase[31:22], 22'd0};
    ival = (y * trig_q14(ef + 32'h4000_0000) + 8192) >>> 14;
    qval = (y * trig_q14(ef) + 8192) >>> 14;
    if (p == 0) begin
      luma_ring[0] = 0;
      inph_ring[0] = 0;
      quad_ring[0] = 0;
    end
    a = p % RING_SIZE;
    b = (p + 1) % RING_SIZE;
    luma_ring[b] = luma_ring[a] + y[23:0];
    inph_ring[b] = inph_ring[a] + ival[31:0];
    quad_ring[b] = quad_ring[a] + qval[31:0];

    while (count < FLUSH_CAP && pix_index < ow) begin
      lo = centre > h ? centre - h : 0;
      hi = centre + h - 1;
      if (hi > spl - 1) hi = spl - 1;
      if (hi > p) break;
      n = 0; ys = 0; is = 0; qs = 0;
      if (lo <= hi) begin
        n = hi - lo + 1;
        dl = luma_ring[(hi + 1) % RING_SIZE] - luma_ring[lo % RING_SIZE];
        di = inph_ring[(hi + 1) % RING_SIZE] - inph_ring[lo % RING_SIZE];
        dq = quad_ring[(hi + 1) % RING_SIZE] - quad_ring[lo % RING_SIZE];
        ys = longint'($signed(dl));
        is = longint'($signed(di));
        qs = longint'($signed(dq));
      end
      if (n == 0) n = 1;
      px.red = colour_byte(ys * 8192 + 2 * (CI_R * is + CQ_R * qs), n);
      px.green = colour_byte(ys * 8192 + 2 * (CI_G * is + CQ_G * qs), n);
      px.blue = colour_byte(ys * 8192 + 2 * (CI_B * is + CQ_B * qs), n);
      px.column = pix_index[11:0];
      px.last = 0;
      pending_pixels.push_back(px);
      count++;
      pix_index++;
      centre += spl / ow;
      centre_rem += spl % ow;
      if (centre_rem >= ow) begin
        centre_rem -= ow;
        centre++;
      end
    end
    if (count > 0) pending_pixels[pending_pixels.size() - 1].last = 1;

    phase += phase_step;
    if (p >= spl - 1) restart_line();
    else position = p + 1;
  endfunction

  function void check_pixel(bit [39:0] data, bit last);
    pixel_t px;
    if (pending_pixels.size() == 0) begin
      $error("unexpected pixel beat, data %h", data);
      errors++;
      return;
    end
    px = pending_pixels.pop_front();
    if (data[7:0] != px.red) begin
      $error("red: expected %0d, actual %0d", px.red, data[7:0]);
      errors++;
    end
    if (data[15:8] != px.green) begin
      $error("green: expected %0d, actual %0d", px.green, data[15:8]);
      errors++;
    end
    if (data[23:16] != px.blue) begin
      $error("blue: expected %0d, actual %0d", px.blue, data[23:16]);
      errors++;
    end
    if (data[35:24] != px.column) begin
      $error("column: expected %0d, actual %0d", px.column, data[35:24]);
      errors++;
    end
    if (last != px.last) begin
      $error("last: expected %0d, actual %0d", px.last, last);
      errors++;
    end
  endfunction
endclass

module tb;
  import cvd_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 300;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [15:0] in_tdata = 0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 0;
  logic [1:0]  cfg_addr = 0;
  logic [31:0] cfg_wdata = 0;

  int gap_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  pixel_scoreboard sb = new();

  composite_video_yiq_demodulator DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata, out_tlast);
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_sample(bit [15:0] s, bit fs);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_tvalid <= 1;
    in_tdata <= s;
    in_tuser <= fs;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s, fs);
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(bit [31:0] step, bit [12:0] spl, bit [12:0] ow, bit [4:0] h);
    bit [31:0] vals [4];
    logic [1:0] idx [4];
    vals = '{step, 32'(spl), 32'(ow), 32'(h)};
    idx = '{REG_PHASE_STEP, REG_SAMPLES_PER_LINE, REG_OUT_WIDTH, REG_HALF_WINDOW};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_addr <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(i, vals[i]);
    end
    cfg_we <= 0;
  endtask

  function automatic bit [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(4096 + $urandom_range(0, 511) - 256);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    bit [15:0] directed [] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h1000, 16'hFFFF, 16'h5555,
                               16'hAAAA, 16'h0800, 16'hF000, 16'h0001};
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // Extremes at the reset settings, a frame start in the middle.
    foreach (directed[i]) send_sample(directed[i], i == 6);
    // A one-sample line with the smallest window, then registers below range.
    write_regs(32'hFFFF_FFFF, 13'd1, 13'd1, 5'd2);
    for (int i = 0; i < 5; i++) send_sample(directed[i], 0);
    write_regs(32'd0, 13'd0, 13'd0, 5'd0);
    for (int i = 0; i < 5; i++) send_sample(directed[i + 5], i == 2);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_regs($urandom, 13'd24, 13'd24, 5'd16);
        1: write_regs(32'd1, 13'd50, 13'd13, 5'd5);
        2: write_regs($urandom, 13'd8191, 13'd8191, 5'd31);
        3: write_regs($urandom, 13'd40, 13'd40, 5'd16);
        4: write_regs($urandom, 13'($urandom_range(1, 64)), 13'($urandom_range(0, 80)),
                      5'($urandom_range(0, 31)));
        5: write_regs(32'h4000_0000, 13'd910, 13'd640, 5'd2);
        6: write_regs($urandom, 13'd17, 13'd30, 5'd1);
        default: write_regs($urandom, 13'($urandom_range(1, 120)),
                            13'($urandom_range(1, 120)), 5'($urandom_range(2, 16)));
      endcase
      case (ph % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 50; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 50; end
        default: begin gap_pct = 9; stall_pct = 9; end
      endcase
      for (int i = 0; i < 21; i++) begin
        if (ph == 2 && i == 10) begin
          in_tvalid <= 0;
          while (sb.pending_pixels.size() != 0) @(posedge clk);
        end
        send_sample(pick_sample(), $urandom_range(0, 29) == 0);
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
